[rtl/sll_pkg.sv]
// Shared types and constants for the stereo ladder lowpass filter.
`default_nettype none
package sll_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int STATE_WIDTH_DEF  = 28;
   localparam int VALUE_WIDTH_DEF  = STATE_WIDTH_DEF + 6;

   localparam int COEF_WIDTH      = 16;
   localparam int TANH_FRAC       = 23;
   localparam int MUL_B_WIDTH     = 30;
   localparam int MUL_CNT_WIDTH   = 5;
   localparam int MAG_WIDTH       = 26;
   localparam int SQ_WIDTH        = 27;
   localparam int NUM_WIDTH       = 54;
   localparam int DEN_WIDTH       = 30;
   localparam int QUO_WIDTH       = 24;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [COEF_WIDTH-1:0] ALPHA_RESET = 16'd39290;
   localparam logic [COEF_WIDTH-1:0] COMP_RESET  = 16'd41478;
   localparam logic [COEF_WIDTH-1:0] RES_RESET   = 16'd0;
   localparam logic [COEF_WIDTH-1:0] DRIVE_RESET = 16'd2048;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ALPHA = 3'd0,
      CSR_COMP  = 3'd1,
      CSR_RES   = 3'd2,
      CSR_DRIVE = 3'd3,
      CSR_MODE  = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DRVX,
      S_DRVX_W,
      S_DRVF,
      S_DRVF_W,
      S_RES,
      S_RES_W,
      S_STG,
      S_STG_W,
      S_OUT,
      S_OUT_W,
      S_CEND,
      S_DONE,
      S_TCHK,
      S_TSQ,
      S_TNUMS,
      S_TNUM,
      S_TDIV
   } state_type;

   typedef struct packed {
      logic                     start;
      logic [MUL_CNT_WIDTH-1:0] len;
   } mul_ctl_type;

endpackage
`default_nettype wire

[rtl/stereo_ladder_lowpass.sv]
// Stereo ladder lowpass, two-pole or four-pole by mode, with rational tanh saturation.
// One stereo pair is processed per item, left channel then right, through one shared
// bit-serial multiplier and one restoring divider; a tanh whose argument saturates
// skips both. The next item can be accepted as soon as the result has moved to the output
// register, which waits while the previous result is still held there. csr_ready is always
// high; write registers only while the block is idle.
`default_nettype none
module stereo_ladder_lowpass #(
   parameter int SAMPLE_WIDTH = sll_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = sll_pkg::STATE_WIDTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0]         req_left_in,
   input  wire logic signed [SAMPLE_WIDTH-1:0]         req_right_in,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_right_out,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [sll_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [sll_pkg::COEF_WIDTH-1:0]         csr_data
);
   localparam int SW     = SAMPLE_WIDTH;
   localparam int STW    = STATE_WIDTH;
   localparam int FRAC   = SW - 1;
   localparam int TF     = sll_pkg::TANH_FRAC;
   localparam int VW     = ((SW > STW) ? SW : STW) + 6;
   localparam int BW     = sll_pkg::MUL_B_WIDTH;
   localparam int PW     = VW + BW;
   localparam int CW     = sll_pkg::COEF_WIDTH;
   localparam int MW     = sll_pkg::MAG_WIDTH;
   localparam int QSW    = sll_pkg::SQ_WIDTH;
   localparam int NW     = sll_pkg::NUM_WIDTH;
   localparam int DW     = sll_pkg::DEN_WIDTH;
   localparam int QW     = sll_pkg::QUO_WIDTH;
   localparam int SH_DN  = (FRAC >= TF) ? FRAC - TF : 0;
   localparam int SH_UP  = (FRAC < TF) ? TF - FRAC : 0;

   localparam logic signed [VW-1:0] LIM    = VW'(64'sd3 <<< FRAC);
   localparam logic signed [VW-1:0] NLIM   = VW'(-(64'sd3 <<< FRAC));
   localparam logic signed [VW-1:0] ONE    = VW'(64'sd1 <<< FRAC);
   localparam logic signed [VW-1:0] ST_MAX = VW'((64'sd1 <<< (STW - 1)) - 64'sd1);
   localparam logic signed [VW-1:0] ST_MIN = VW'(-(64'sd1 <<< (STW - 1)));
   localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic [DW-1:0] K27 = DW'(64'd27 << TF);

   function automatic logic signed [STW-1:0] sat_st(input logic signed [VW-1:0] v);
      logic signed [STW-1:0] r;
      if (v > ST_MAX) begin
         r = ST_MAX[STW-1:0];
      end else if (v < ST_MIN) begin
         r = ST_MIN[STW-1:0];
      end else begin
         r = v[STW-1:0];
      end
      return r;
   endfunction

   sll_pkg::state_type            state_ff, state_in, ret_ff, ret_in;
   logic                          chan_ff, chan_in;
   logic [1:0]                    idx_ff, idx_in;
   logic signed [SW-1:0]          smp_ff [2];
   logic signed [SW-1:0]          smp_in [2];
   logic signed [STW-1:0]         st_ff [2][4];
   logic signed [STW-1:0]         st_in [2][4];
   logic signed [VW-1:0]          tx_ff, tx_in, th_ff, th_in, tin_ff, tin_in;
   logic signed [STW-1:0]         u_ff, u_in;
   logic [MW-1:0]                 m_ff, m_in;
   logic                          neg_ff, neg_in;
   logic [QSW-1:0]                m2_ff, m2_in;
   logic signed [SW-1:0]          out_ff [2];
   logic signed [SW-1:0]          out_in [2];
   logic signed [SW-1:0]          rl_ff, rl_in, rr_ff, rr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                 alpha_ff, alpha_in, comp_ff, comp_in;
   logic [CW-1:0]                 res_ff, res_in, drive_ff, drive_in;
   logic                          four_ff, four_in;

   sll_pkg::mul_ctl_type          mul_ctl;
   logic signed [VW-1:0]          mul_a;
   logic [BW-1:0]                 mul_b;
   logic                          mul_busy;
   logic signed [PW-1:0]          mul_prod;
   logic                          div_start, div_busy;
   logic [NW-1:0]                 div_num;
   logic [DW-1:0]                 div_den;
   logic [QW-1:0]                 div_quo;

   logic signed [STW-1:0]         cur_st, prev_st, last_st;
   logic [1:0]                    last_idx;
   logic signed [VW-1:0]          a_val, mag, t_val, t_conv;
   logic [DW-1:0]                 den_val;

   sll_serial_mul #(.A_WIDTH(VW)) u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .prod  (mul_prod)
   );

   sll_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      chan_in      = chan_ff;
      idx_in       = idx_ff;
      smp_in       = smp_ff;
      st_in        = st_ff;
      tx_in        = tx_ff;
      th_in        = th_ff;
      tin_in       = tin_ff;
      u_in         = u_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      m2_in        = m2_ff;
      out_in       = out_ff;
      rl_in        = rl_ff;
      rr_in        = rr_ff;
      rsp_valid_in = rsp_valid_ff;
      alpha_in     = alpha_ff;
      comp_in      = comp_ff;
      res_in       = res_ff;
      drive_in     = drive_ff;
      four_in      = four_ff;
      req_ready    = 1'b0;
      mul_ctl      = '0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;

      last_idx = four_ff ? 2'd3 : 2'd1;
      cur_st   = st_ff[chan_ff][idx_ff];
      prev_st  = (idx_ff == 2'd0) ? u_ff : st_ff[chan_ff][idx_ff - 2'd1];
      last_st  = st_ff[chan_ff][last_idx];

      // tanh argument brought to 23 fractional bits
      a_val   = (FRAC >= TF) ? (tx_ff >>> SH_DN) : (tx_ff <<< SH_UP);
      mag     = a_val[VW-1] ? -a_val : a_val;
      den_val = K27 + {m2_ff, 3'b000} + DW'(m2_ff);
      t_val   = neg_ff ? -VW'({1'b0, div_quo}) : VW'({1'b0, div_quo});
      t_conv  = (FRAC >= TF) ? (t_val <<< SH_DN) : (t_val >>> SH_UP);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            sll_pkg::CSR_ALPHA: alpha_in = csr_data;
            sll_pkg::CSR_COMP:  comp_in  = csr_data;
            sll_pkg::CSR_RES:   res_in   = csr_data;
            sll_pkg::CSR_DRIVE: drive_in = csr_data;
            sll_pkg::CSR_MODE:  four_in  = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         sll_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               smp_in[0] = req_left_in;
               smp_in[1] = req_right_in;
               chan_in   = 1'b0;
               state_in  = sll_pkg::S_DRVX;
            end
         end
         sll_pkg::S_DRVX: begin
            mul_ctl.start = 1'b1;
            mul_ctl.len   = sll_pkg::MUL_CNT_WIDTH'(CW);
            mul_a         = VW'(smp_ff[chan_ff]);
            mul_b         = {drive_ff, {(BW-CW){1'b0}}};
            state_in      = sll_pkg::S_DRVX_W;
         end
         sll_pkg::S_DRVX_W: begin
            if (!mul_busy) begin
               // drive times half the input
               tx_in    = VW'(mul_prod >>> 12);
               ret_in   = sll_pkg::S_DRVF;
               state_in = sll_pkg::S_TCHK;
            end
         end
         sll_pkg::S_DRVF: begin
            tin_in        = th_ff;
            mul_ctl.start = 1'b1;
            mul_ctl.len   = sll_pkg::MUL_CNT_WIDTH'(CW);
            mul_a         = VW'(last_st);
            mul_b         = {drive_ff, {(BW-CW){1'b0}}};
            state_in      = sll_pkg::S_DRVF_W;
         end
         sll_pkg::S_DRVF_W: begin
            if (!mul_busy) begin
               tx_in    = VW'(mul_prod >>> 11);
               ret_in   = sll_pkg::S_RES;
               state_in = sll_pkg::S_TCHK;
            end
         end
         sll_pkg::S_RES: begin
            mul_ctl.start = 1'b1;
            mul_ctl.len   = sll_pkg::MUL_CNT_WIDTH'(CW);
            mul_a         = th_ff;
            mul_b         = {res_ff, {(BW-CW){1'b0}}};
            state_in      = sll_pkg::S_RES_W;
         end
         sll_pkg::S_RES_W: begin
            if (!mul_busy) begin
               u_in     = sat_st(tin_ff - VW'(mul_prod >>> 13));
               idx_in   = 2'd0;
               state_in = sll_pkg::S_STG;
            end
         end
         sll_pkg::S_STG: begin
            mul_ctl.start = 1'b1;
            mul_ctl.len   = sll_pkg::MUL_CNT_WIDTH'(CW);
            mul_a         = VW'(prev_st) - VW'(cur_st);
            mul_b         = {alpha_ff, {(BW-CW){1'b0}}};
            state_in      = sll_pkg::S_STG_W;
         end
         sll_pkg::S_STG_W: begin
            if (!mul_busy) begin
               st_in[chan_ff][idx_ff] = sat_st(VW'(cur_st) + VW'(mul_prod >>> 16));
               if (idx_ff == last_idx) begin
                  state_in = sll_pkg::S_OUT;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = sll_pkg::S_STG;
               end
            end
         end
         sll_pkg::S_OUT: begin
            mul_ctl.start = 1'b1;
            mul_ctl.len   = sll_pkg::MUL_CNT_WIDTH'(CW);
            mul_a         = VW'(last_st);
            mul_b         = {comp_ff, {(BW-CW){1'b0}}};
            state_in      = sll_pkg::S_OUT_W;
         end
         sll_pkg::S_OUT_W: begin
            if (!mul_busy) begin
               tx_in    = VW'(mul_prod >>> 16);
               ret_in   = sll_pkg::S_CEND;
               state_in = sll_pkg::S_TCHK;
            end
         end
         sll_pkg::S_CEND: begin
            out_in[chan_ff] = (th_ff >= ONE) ? SMP_MAX : th_ff[SW-1:0];
            if (!chan_ff) begin
               chan_in  = 1'b1;
               state_in = sll_pkg::S_DRVX;
            end else begin
               state_in = sll_pkg::S_DONE;
            end
         end
         sll_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rl_in        = out_ff[0];
               rr_in        = out_ff[1];
               rsp_valid_in = 1'b1;
               state_in     = sll_pkg::S_IDLE;
            end
         end
         sll_pkg::S_TCHK: begin
            if (tx_ff >= LIM) begin
               th_in    = ONE;
               state_in = ret_ff;
            end else if (tx_ff <= NLIM) begin
               th_in    = -ONE;
               state_in = ret_ff;
            end else begin
               m_in          = mag[MW-1:0];
               neg_in        = a_val[VW-1];
               mul_ctl.start = 1'b1;
               mul_ctl.len   = sll_pkg::MUL_CNT_WIDTH'(BW);
               mul_a         = VW'({1'b0, mag[MW-1:0]});
               mul_b         = BW'(mag[MW-1:0]);
               state_in      = sll_pkg::S_TSQ;
            end
         end
         sll_pkg::S_TSQ: begin
            if (!mul_busy) begin
               m2_in    = mul_prod[TF +: QSW];
               state_in = sll_pkg::S_TNUMS;
            end
         end
         sll_pkg::S_TNUMS: begin
            mul_ctl.start = 1'b1;
            mul_ctl.len   = sll_pkg::MUL_CNT_WIDTH'(BW);
            mul_a         = VW'({1'b0, m_ff});
            mul_b         = K27 + BW'(m2_ff);
            state_in      = sll_pkg::S_TNUM;
         end
         sll_pkg::S_TNUM: begin
            if (!mul_busy) begin
               div_start = 1'b1;
               div_num   = mul_prod[NW-1:0];
               div_den   = den_val;
               state_in  = sll_pkg::S_TDIV;
            end
         end
         sll_pkg::S_TDIV: begin
            if (!div_busy) begin
               th_in    = t_conv;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = sll_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sll_pkg::S_IDLE;
         ret_ff       <= sll_pkg::S_IDLE;
         chan_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= sll_pkg::ALPHA_RESET;
         comp_ff      <= sll_pkg::COMP_RESET;
         res_ff       <= sll_pkg::RES_RESET;
         drive_ff     <= sll_pkg::DRIVE_RESET;
         four_ff      <= 1'b0;
         for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 4; k++) begin
               st_ff[c][k] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         chan_ff      <= chan_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         alpha_ff     <= alpha_in;
         comp_ff      <= comp_in;
         res_ff       <= res_in;
         drive_ff     <= drive_in;
         four_ff      <= four_in;
         st_ff        <= st_in;
      end
      smp_ff <= smp_in;
      tx_ff  <= tx_in;
      th_ff  <= th_in;
      tin_ff <= tin_in;
      u_ff   <= u_in;
      m_ff   <= m_in;
      neg_ff <= neg_in;
      m2_ff  <= m2_in;
      out_ff <= out_in;
      rl_ff  <= rl_in;
      rr_ff  <= rr_in;
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rl_ff;
   assign rsp_right_out = rr_ff;
endmodule
`default_nettype wire

[rtl/sll_serial_mul.sv]
// Bit-serial shift-add multiplier: signed A by unsigned B, B taken MSB first.
`default_nettype none
module sll_serial_mul #(
   parameter int A_WIDTH = sll_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire sll_pkg::mul_ctl_type                          ctl,
   input  wire logic signed [A_WIDTH-1:0]                     a,
   input  wire logic        [sll_pkg::MUL_B_WIDTH-1:0]        b,
   output logic                                               busy,
   output logic signed [A_WIDTH+sll_pkg::MUL_B_WIDTH-1:0]     prod
);
   localparam int PW = A_WIDTH + sll_pkg::MUL_B_WIDTH;

   logic signed [PW-1:0]                    acc_ff, acc_in;
   logic signed [A_WIDTH-1:0]               a_ff, a_in;
   logic [sll_pkg::MUL_B_WIDTH-1:0]         b_ff, b_in;
   logic [sll_pkg::MUL_CNT_WIDTH-1:0]       cnt_ff, cnt_in;

   always_comb begin
      acc_in = acc_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      cnt_in = cnt_ff;
      if (ctl.start) begin
         acc_in = '0;
         a_in   = a;
         b_in   = b;
         cnt_in = ctl.len;
      end else if (cnt_ff != '0) begin
         acc_in = (acc_ff <<< 1) + (b_ff[sll_pkg::MUL_B_WIDTH-1] ? PW'(a_ff) : PW'(0));
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign busy = (cnt_ff != '0);
   assign prod = acc_ff;
endmodule
`default_nettype wire

[rtl/sll_serial_div.sv]
// Restoring divider, one quotient bit per cycle, for the rational tanh.
`default_nettype none
module sll_serial_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [sll_pkg::NUM_WIDTH-1:0]    num,
   input  wire logic [sll_pkg::DEN_WIDTH-1:0]    den,
   output logic                                  busy,
   output logic [sll_pkg::QUO_WIDTH-1:0]         quo
);
   localparam int QW = sll_pkg::QUO_WIDTH;
   localparam int DW = sll_pkg::DEN_WIDTH;

   logic [DW:0]                        rem_ff, rem_in;
   logic [DW-1:0]                      den_ff, den_in;
   logic [QW-1:0]                      n_ff, n_in;
   logic [QW-1:0]                      q_ff, q_in;
   logic [sll_pkg::MUL_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [DW:0]                        trial;

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      n_in   = n_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff[DW-1:0], n_ff[QW-1]};
      if (start) begin
         // quotient is known to stay below 2^QW, so the top part starts below den
         rem_in = {1'b0, num[sll_pkg::NUM_WIDTH-1:QW]};
         den_in = den;
         n_in   = num[QW-1:0];
         q_in   = '0;
         cnt_in = sll_pkg::MUL_CNT_WIDTH'(QW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         n_in   = n_ff << 1;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
   end

   assign busy = (cnt_ff != '0);
   assign quo  = q_ff;
endmodule
`default_nettype wire

[rtl/sll_checker.sv]
// Port-level checks for the stereo ladder lowpass, bound to the top level.
`default_nettype none
module sll_checker #(
   parameter int SAMPLE_WIDTH = sll_pkg::SAMPLE_WIDTH_DEF
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   input wire logic signed [SAMPLE_WIDTH-1:0] rsp_right_out
);
   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out)
                                  && $stable(rsp_right_out))
      else $error("result changed while stalled");

   // an accepted item keeps the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an item");

   // a fresh result frees the input side at once
   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result shown while input side busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");
endmodule

bind stereo_ladder_lowpass sll_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sll_checker (.*);
`default_nettype wire
